// ===== rtl/tcw_pkg.sv =====
// Shared types and constants for the text console character writer.
package tcw_pkg;

  localparam int DEF_ROWS = 25;
  localparam int DEF_COLS = 80;

  localparam int CMD_W    = 2;
  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int IDX_W    = 11;
  localparam int CURSOR_W = 11;
  localparam int CELL_W   = 16;

  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [ATTR_W-1:0] DEFAULT_ATTR = 8'h07;
  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;
  localparam logic [2:0]        TAB_SPACES   = 3'd5;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] char_code;
    logic [ATTR_W-1:0] attribute;
    logic [IDX_W-1:0]  cell_index;
  } cmd_t;

  typedef struct packed {
    logic                valid;
    logic [CURSOR_W-1:0] cursor_position;
    logic [CELL_W-1:0]   cell_value;
  } res_t;

endpackage

// ===== rtl/text_console_char_writer_core.sv =====
// Text console character writer: stream ports and result register.
//
// Input channel s_axis: one command per transfer. tuser carries the command
// (put character, read cell, clear screen); tdata carries the character,
// the attribute and the cell index for a read.
// Output channel m_axis: one result per command with the cursor position
// after the command and, for a read, the cell contents (zero otherwise).
//
// Work per command, with N = ROWS*COLS cells held in one memory:
//   read: memory read, then S_READ; ordinary put, backspace, newline, return: an S_PUT step
//   unused command: straight to the result
//   tab: five space puts
//   a put that passes the last cell adds a scroll, one cell copied per cycle
//   through the read/write memory ports, with the bottom row refilled blank
//   clear: one cell zeroed per cycle over all N cells
// After reset the memory is swept to zero over all N cells (2000 at 25x80);
// s_axis_tready stays low until that pass is done.
// One command is worked on at a time. A finished result sits in the output
// register while the next command is taken; with the receiver stalled the
// sequencer holds the following result and input stops being taken.
module text_console_char_writer_core #(
  parameter int ROWS = tcw_pkg::DEF_ROWS,
  parameter int COLS = tcw_pkg::DEF_COLS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // char_code[7:0], attribute[15:8], cell_index[26:16]
  input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // cursor_position[10:0], cell_value[26:11]
);

  tcw_pkg::cmd_t cmd_in;
  tcw_pkg::res_t res;
  logic          res_ready;
  logic [tcw_pkg::CURSOR_W-1:0] out_cursor;
  logic [tcw_pkg::CELL_W-1:0]   out_value;

  assign cmd_in.cmd        = s_axis_tuser;
  assign cmd_in.char_code  = s_axis_tdata[7:0];
  assign cmd_in.attribute  = s_axis_tdata[15:8];
  assign cmd_in.cell_index = s_axis_tdata[26:16];

  tcw_ctrl #(.ROWS(ROWS), .COLS(COLS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (s_axis_tvalid),
    .cmd_ready (s_axis_tready),
    .cmd_in    (cmd_in),
    .res       (res),
    .res_ready (res_ready)
  );

  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      out_cursor <= res.cursor_position;
      out_value  <= res.cell_value;
    end
  end

  assign m_axis_tdata = {5'd0, out_value, out_cursor};

endmodule

// ===== rtl/tcw_screen_ram.sv =====
// Screen cell memory: one write port, one registered read port.
module tcw_screen_ram #(
  parameter int DEPTH = tcw_pkg::DEF_ROWS * tcw_pkg::DEF_COLS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [tcw_pkg::CELL_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [tcw_pkg::CELL_W-1:0] rdata
);

  logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/tcw_ctrl.sv =====
// Command sequencer: cursor tracking, put, read, clear sweep and scroll copy.
module tcw_ctrl #(
  parameter int ROWS = tcw_pkg::DEF_ROWS,
  parameter int COLS = tcw_pkg::DEF_COLS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  tcw_pkg::cmd_t cmd_in,
  output tcw_pkg::res_t res,
  input  logic          res_ready
);

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS + 1);
  localparam int KW    = $clog2(COLS);

  localparam logic [AW:0]   CELLS_C = (AW+1)'(CELLS);
  localparam logic [AW:0]   COLS_C  = (AW+1)'(COLS);
  localparam logic [AW:0]   KEEP_C  = (AW+1)'(CELLS - COLS);
  localparam logic [AW-1:0] LAST_C  = AW'(CELLS - 1);
  localparam logic [RW-1:0] ROWS_C  = RW'(ROWS);
  localparam logic [RW-1:0] LROW_C  = RW'(ROWS - 1);
  localparam logic [KW-1:0] LCOL_C  = KW'(COLS - 1);

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_PUT     = 3'd2;
  localparam logic [2:0] S_SCR_PRE = 3'd3;
  localparam logic [2:0] S_SCR_RUN = 3'd4;
  localparam logic [2:0] S_READ    = 3'd5;
  localparam logic [2:0] S_DONE    = 3'd6;

  logic [2:0]    state;
  logic [AW-1:0] cursor;
  logic [RW-1:0] row;
  logic [KW-1:0] col;
  logic [AW-1:0] addr;
  logic          clr_reply;
  logic [2:0]    reps;
  logic [tcw_pkg::CELL_W-1:0] glyph;
  logic [tcw_pkg::CELL_W-1:0] value;

  logic                       we;
  logic [AW-1:0]              waddr;
  logic [tcw_pkg::CELL_W-1:0] wdata;
  logic                       re;
  logic [AW-1:0]              raddr;
  logic [tcw_pkg::CELL_W-1:0] rdata;

  // One put step
  logic [AW:0]   t_cur;
  logic [RW-1:0] t_row;
  logic [KW-1:0] t_col;
  logic          p_we;
  logic [AW-1:0] p_waddr;
  logic [tcw_pkg::CELL_W-1:0] p_wdata;
  logic          p_scroll;
  logic [AW:0]   col_ext;

  logic                       accept;
  logic                       idx_ok;
  logic [tcw_pkg::ATTR_W-1:0] hi;
  logic [AW:0]                scr_rd;

  tcw_screen_ram #(.DEPTH(CELLS), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign cmd_ready = (state == S_IDLE);
  assign accept    = cmd_valid && cmd_ready;
  assign idx_ok    = ((AW+1)'(cmd_in.cell_index) < CELLS_C) && ((AW+1) > tcw_pkg::IDX_W ||
                     cmd_in.cell_index < tcw_pkg::IDX_W'(CELLS));
  assign hi        = (cmd_in.attribute == '0) ? tcw_pkg::DEFAULT_ATTR : cmd_in.attribute;
  assign col_ext   = (AW+1)'(col);
  assign scr_rd    = (AW+1)'(addr) + COLS_C + (AW+1)'(1);

  always_comb begin
    t_cur   = (AW+1)'(cursor);
    t_row   = row;
    t_col   = col;
    p_we    = 1'b0;
    p_waddr = cursor;
    p_wdata = glyph;
    unique case (glyph[7:0])
      tcw_pkg::CH_BS: begin
        if (cursor != '0) begin
          t_cur   = (AW+1)'(cursor) - (AW+1)'(1);
          p_we    = 1'b1;
          p_waddr = cursor - AW'(1);
          p_wdata = {glyph[15:8], tcw_pkg::CH_SPACE};
          if (col == '0) begin
            t_col = LCOL_C;
            t_row = row - RW'(1);
          end else begin
            t_col = col - KW'(1);
          end
        end
      end
      tcw_pkg::CH_LF: begin
        t_cur = (AW+1)'(cursor) - col_ext + COLS_C;
        t_col = '0;
        t_row = row + RW'(1);
      end
      tcw_pkg::CH_CR: begin
        t_cur = (AW+1)'(cursor) - col_ext;
        t_col = '0;
      end
      default: begin
        p_we  = 1'b1;
        t_cur = (AW+1)'(cursor) + (AW+1)'(1);
        if (col == LCOL_C) begin
          t_col = '0;
          t_row = row + RW'(1);
        end else begin
          t_col = col + KW'(1);
        end
      end
    endcase
    p_scroll = (t_row == ROWS_C);
  end

  always_comb begin
    we    = 1'b0;
    waddr = addr;
    wdata = '0;
    re    = 1'b0;
    raddr = AW'(cmd_in.cell_index);
    unique case (state)
      S_CLEAR: begin
        we = 1'b1;
      end
      S_IDLE: begin
        re = accept && (cmd_in.cmd == tcw_pkg::CMD_READ) && idx_ok;
      end
      S_PUT: begin
        we    = p_we;
        waddr = p_waddr;
        wdata = p_wdata;
      end
      S_SCR_PRE: begin
        re    = 1'b1;
        raddr = AW'(COLS_C);
      end
      S_SCR_RUN: begin
        we    = 1'b1;
        wdata = ((AW+1)'(addr) < KEEP_C) ? rdata : tcw_pkg::BLANK_CELL;
        re    = (scr_rd < CELLS_C);
        raddr = AW'(scr_rd);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      addr      <= '0;
      clr_reply <= 1'b0;
      cursor    <= '0;
      row       <= '0;
      col       <= '0;
      reps      <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          addr <= addr + AW'(1);
          if (addr == LAST_C) begin
            state <= clr_reply ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            value <= '0;
            unique case (cmd_in.cmd)
              tcw_pkg::CMD_PUT: begin
                state <= S_PUT;
                if (cmd_in.char_code == tcw_pkg::CH_TAB) begin
                  reps  <= tcw_pkg::TAB_SPACES;
                  glyph <= tcw_pkg::BLANK_CELL;
                end else begin
                  reps  <= 3'd1;
                  glyph <= {hi, cmd_in.char_code};
                end
              end
              tcw_pkg::CMD_READ: begin
                state    <= S_READ;
                glyph[0] <= idx_ok;
              end
              tcw_pkg::CMD_CLEAR: begin
                state     <= S_CLEAR;
                addr      <= '0;
                clr_reply <= 1'b1;
                cursor    <= '0;
                row       <= '0;
                col       <= '0;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_PUT: begin
          reps <= reps - 3'd1;
          col  <= t_col;
          if (p_scroll) begin
            cursor <= AW'(t_cur - COLS_C);
            row    <= LROW_C;
            state  <= S_SCR_PRE;
          end else begin
            cursor <= AW'(t_cur);
            row    <= t_row;
            state  <= (reps == 3'd1) ? S_DONE : S_PUT;
          end
        end
        S_SCR_PRE: begin
          addr  <= '0;
          state <= S_SCR_RUN;
        end
        S_SCR_RUN: begin
          addr <= addr + AW'(1);
          if (addr == LAST_C) begin
            state <= (reps == '0) ? S_DONE : S_PUT;
          end
        end
        S_READ: begin
          value <= glyph[0] ? rdata : '0;
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state     <= S_IDLE;
            clr_reply <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res.valid           = (state == S_DONE);
  assign res.cursor_position = tcw_pkg::CURSOR_W'(cursor);
  assign res.cell_value      = value;

endmodule

// ===== tb/text_console_char_writer_core_test.sv =====
// Self-checking stream testbench for the text console character writer core.
module text_console_char_writer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS           = tcw_pkg::DEF_ROWS;
  localparam int COLS           = tcw_pkg::DEF_COLS;
  localparam int SCREEN         = ROWS * COLS;
  localparam int RANDOM_ITEMS   = 1000;
  localparam int DRAIN_EVERY    = 250;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 100;

  localparam int CMD_W    = tcw_pkg::CMD_W;
  localparam int CHAR_W   = tcw_pkg::CHAR_W;
  localparam int ATTR_W   = tcw_pkg::ATTR_W;
  localparam int IDX_W    = tcw_pkg::IDX_W;
  localparam int CURSOR_W = tcw_pkg::CURSOR_W;
  localparam int CELL_W   = tcw_pkg::CELL_W;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [CURSOR_W-1:0] cursor;
    logic [CELL_W-1:0]   value;
  } console_result_t;

  class console_scoreboard;
    logic [CELL_W-1:0] cells [SCREEN];
    int unsigned       cursor;
    console_result_t   expected_q[$];
    int                errors;
    int                results_seen;

    function new();
      errors = 0;
      results_seen = 0;
      clear_screen();
    endfunction

    function void clear_screen();
      foreach (cells[i]) cells[i] = '0;
      cursor = 0;
    endfunction

    function void scroll_check();
      if (cursor >= SCREEN) begin
        for (int i = 0; i < SCREEN - COLS; i++) cells[i] = cells[i + COLS];
        for (int i = SCREEN - COLS; i < SCREEN; i++) cells[i] = tcw_pkg::BLANK_CELL;
        cursor -= COLS;
      end
    endfunction

    function void write_glyph(logic [CELL_W-1:0] word);
      if (cursor < SCREEN) cells[cursor] = word;
      cursor++;
      scroll_check();
    endfunction

    function void put_cell(logic [CELL_W-1:0] word);
      case (word[7:0])
        tcw_pkg::CH_BS: begin
          if (cursor > 0) begin
            cursor--;
            cells[cursor] = {word[15:8], tcw_pkg::CH_SPACE};
          end
        end
        tcw_pkg::CH_LF: begin
          cursor += COLS;
          cursor -= cursor % COLS;
        end
        tcw_pkg::CH_CR: cursor -= cursor % COLS;
        tcw_pkg::CH_TAB: begin
          repeat (tcw_pkg::TAB_SPACES)
            write_glyph({tcw_pkg::DEFAULT_ATTR, tcw_pkg::CH_SPACE});
        end
        default: write_glyph(word);
      endcase
      scroll_check();
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                               logic [ATTR_W-1:0] attr, logic [IDX_W-1:0] idx);
      console_result_t   r;
      logic [ATTR_W-1:0] hi;
      r.value = '0;
      hi = (attr == '0) ? tcw_pkg::DEFAULT_ATTR : attr;
      case (cmd)
        tcw_pkg::CMD_PUT:   put_cell({hi, ch});
        tcw_pkg::CMD_READ:  if (idx < SCREEN) r.value = cells[idx];
        tcw_pkg::CMD_CLEAR: clear_screen();
        default: ;
      endcase
      r.cursor = cursor[CURSOR_W-1:0];
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [31:0] data);
      console_result_t     r;
      logic [CURSOR_W-1:0] cur;
      logic [CELL_W-1:0]   val;
      cur = data[10:0];
      val = data[26:11];
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result %0d not expected: cursor %0d cell %h",
                                  results_seen, cur, val));
        return;
      end
      r = expected_q.pop_front();
      if (cur !== r.cursor)
        report_mismatch($sformatf("result %0d cursor %0d, expected %0d",
                                  results_seen, cur, r.cursor));
      if (val !== r.value)
        report_mismatch($sformatf("result %0d cell %h, expected %h",
                                  results_seen, val, r.value));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // char_code[7:0], attribute[15:8], cell_index[26:16]
  logic [1:0]  s_axis_tuser = '0;   // cmd[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // cursor_position[10:0], cell_value[26:11]

  console_scoreboard sb = new();

  int unsigned stall_count = 0;
  int unsigned ready_left = 0;
  int unsigned ready_mode = 0;
  logic [7:0]  ready_pattern = 8'hff;
  int unsigned newline_run = 0;

  text_console_char_writer_core #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready)
        sb.note_command(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8],
                        s_axis_tdata[26:16]);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
      if (stall_count >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, stall_count);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // receiver backpressure: always ready, coin flip, mostly stalled, rotating pattern
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode    <= $urandom_range(0, 3);
      ready_left    <= $urandom_range(10, 200);
      ready_pattern <= 8'($urandom_range(0, 255));
    end else begin
      ready_left    <= ready_left - 1;
      ready_pattern <= {ready_pattern[6:0], ready_pattern[7]};
    end
    case (ready_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= ready_pattern[0];
    endcase
  end

  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                              input logic [ATTR_W-1:0] attr, input logic [IDX_W-1:0] idx);
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {5'b0, idx, attr, ch};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic pause_input(input int unsigned cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (sb.expected_q.size() != 0);
  endtask

  task automatic pick_command(output logic [CMD_W-1:0] cmd, output logic [CHAR_W-1:0] ch,
                              output logic [ATTR_W-1:0] attr, output logic [IDX_W-1:0] idx);
    int unsigned w;
    int unsigned pick;
    w    = $urandom_range(0, 99);
    cmd  = tcw_pkg::CMD_PUT;
    ch   = 8'($urandom_range(0, 255));
    attr = ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
    idx  = 11'($urandom_range(0, 2047));
    if (newline_run > 0) begin
      newline_run--;
      ch = tcw_pkg::CH_LF;
    end else if (w < 2) begin
      newline_run = $urandom_range(5, 25);
    end else if (w < 6) begin
      ch = tcw_pkg::CH_LF;
    end else if (w < 9) begin
      ch = tcw_pkg::CH_TAB;
    end else if (w < 13) begin
      ch = tcw_pkg::CH_BS;
    end else if (w < 15) begin
      ch = tcw_pkg::CH_CR;
    end else if (w < 16) begin
      cmd = tcw_pkg::CMD_CLEAR;
    end else if (w < 17) begin
      cmd = CMD_UNUSED;
    end else if (w < 32) begin
      cmd  = tcw_pkg::CMD_READ;
      pick = $urandom_range(0, 2);
      if (pick == 0)
        idx = (sb.cursor > 40) ? 11'(sb.cursor - $urandom_range(0, 40))
                               : 11'($urandom_range(0, 40));
      else if (pick == 1)
        idx = 11'($urandom_range(SCREEN - COLS - 20, SCREEN - 1));
    end
  endtask

  initial begin
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] ch;
    logic [ATTR_W-1:0] attr;
    logic [IDX_W-1:0]  idx;
    int unsigned       issued;
    int unsigned       burst;
    int unsigned       gap;
    int unsigned       next_drain;

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    send_command(tcw_pkg::CMD_READ,  8'h00, 8'h00, 11'd0);
    send_command(tcw_pkg::CMD_READ,  8'h00, 8'h00, 11'(SCREEN - 1));
    send_command(tcw_pkg::CMD_READ,  8'h00, 8'h00, 11'(SCREEN));
    send_command(tcw_pkg::CMD_READ,  8'hff, 8'hff, 11'h7ff);
    send_command(tcw_pkg::CMD_PUT,   8'h41, 8'h00, 11'd0);
    send_command(tcw_pkg::CMD_PUT,   8'hff, 8'hff, 11'h7ff);
    send_command(tcw_pkg::CMD_PUT,   8'h00, 8'h01, 11'd0);
    send_command(tcw_pkg::CMD_READ,  8'h00, 8'h00, 11'd0);
    send_command(tcw_pkg::CMD_READ,  8'h00, 8'h00, 11'd1);
    send_command(tcw_pkg::CMD_READ,  8'h00, 8'h00, 11'd2);
    send_command(tcw_pkg::CMD_PUT,   tcw_pkg::CH_TAB, 8'h5a, 11'd0);
    send_command(tcw_pkg::CMD_READ,  8'h00, 8'h00, 11'd4);
    send_command(tcw_pkg::CMD_PUT,   tcw_pkg::CH_BS, 8'ha5, 11'd0);
    send_command(tcw_pkg::CMD_READ,  8'h00, 8'h00, 11'd7);
    send_command(tcw_pkg::CMD_PUT,   tcw_pkg::CH_CR, 8'h00, 11'd0);
    send_command(tcw_pkg::CMD_PUT,   tcw_pkg::CH_LF, 8'h33, 11'd0);
    send_command(CMD_UNUSED,         8'hff, 8'hff, 11'h7ff);
    send_command(tcw_pkg::CMD_CLEAR, 8'h00, 8'h00, 11'd0);
    send_command(tcw_pkg::CMD_PUT,   tcw_pkg::CH_BS, 8'h00, 11'd0);
    send_command(tcw_pkg::CMD_READ,  8'h00, 8'h00, 11'd0);
    send_command(tcw_pkg::CMD_READ,  8'h00, 8'h00, 11'd1);
    wait_results_drained();

    // run to the bottom row so scrolls start early
    newline_run = $urandom_range(26, 30);
    issued      = 0;
    next_drain  = DRAIN_EVERY;
    while (issued < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (burst) begin
        pick_command(cmd, ch, attr, idx);
        send_command(cmd, ch, attr, idx);
        issued++;
      end
      if (gap > 0) pause_input(gap);
      if (issued >= next_drain) begin
        wait_results_drained();
        next_drain += DRAIN_EVERY;
      end
    end

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.expected_q.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.expected_q.size()));
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
